>>> hdl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg: shared constants for the great-circle distance pipeline
// Fixed-point formats, angle reduction constants, CORDIC table and latency.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STAGES_DEF   = 20;

  // Field widths.
  localparam int RADIUS_W = 13;
  localparam int DIST_W   = 23;

  // Angle magnitude in degrees Q.16 before and after folding.
  localparam int MAG_W = 25;
  localparam int DEG_W = 24;

  // CORDIC x/y datapath (signed Q.30 with headroom) and clamped unit values.
  localparam int TRIG_W = 34;
  localparam int UNIT_W = 31;

  // Square root chain: one root bit per cell.
  localparam int SQRT_STEPS = 31;
  localparam int ROOT_W     = 31;
  localparam int REM_W      = 61;

  localparam logic [MAG_W-1:0] DEG_FULL    = 25'd23592960;
  localparam logic [MAG_W-1:0] DEG_HALF    = 25'd11796480;
  localparam logic [MAG_W-1:0] DEG_QUARTER = 25'd5898240;

  // pi/4 in Q.32 split as 45 * PI4_DIV45 + PI4_REM45, so the division by 45
  // only acts on the small remainder product.
  localparam logic [26:0] PI4_DIV45     = 27'd74961320;
  localparam logic [4:0]  PI4_REM45     = 5'd26;
  localparam logic [29:0] RECIP45       = 30'd763549742;
  localparam int          RECIP45_SHIFT = 35;
  localparam int          RAD_SHIFT     = 48;

  localparam logic [TRIG_W-1:0] CORDIC_GAIN = 34'h026DD3B6A;
  localparam logic [UNIT_W-1:0] ONE_Q30     = 31'h40000000;
  localparam int                Q30_FRAC    = 30;

  localparam logic [DIST_W-1:0] DIST_MAX   = 23'h7FFFFF;
  localparam int                DIST_SHIFT = 9;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // Elementary angle atan(2^-idx) with frac fraction bits.
  function automatic logic [31:0] atan_angle(input int idx, input int frac);
    return ATAN_Q30[idx[4:0]] >> (Q30_FRAC - frac);
  endfunction

  // Register stages from an accepted beat to its result strobe.
  function automatic int latency(input int stages);
    return 44 + 2 * stages;
  endfunction

endpackage

>>> hdl/gcd_angle_lane.sv
// ----------------------------------------------------------------------------
// gcd_angle_lane: degree reduction and conversion to radians
// Folds a degree magnitude into range and scales it by pi/180, five stages.
// ----------------------------------------------------------------------------
module gcd_angle_lane #(
  parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter bit COS_FOLD        = 1'b0,
  parameter int EXTRA_SHIFT     = 0
) (
  input  logic                            clk_i,
  input  logic [gcd_pkg::MAG_W-1:0]       mag_i,
  output logic signed [ANGLE_FRAC_BITS+3:0] theta_o,
  output logic                            neg_o
);

  localparam int ZW   = ANGLE_FRAC_BITS + 4;
  localparam int SH   = gcd_pkg::RAD_SHIFT - ANGLE_FRAC_BITS + EXTRA_SHIFT;
  localparam int PW   = 51;
  localparam int XW   = 29;
  localparam int MW   = XW + 30;
  localparam int QW   = 24;
  localparam int SUMW = PW + 1;

  logic [gcd_pkg::MAG_W-1:0] mod_v, fold_v;
  logic [gcd_pkg::DEG_W-1:0] deg_d, deg_q;
  logic                      neg_d, neg_s2_q, neg_s3_q, neg_s4_q, neg_s5_q, neg_q;
  logic [PW-1:0]             hi_d, hi_q, hi_s4_q, p_d, p_q;
  logic [XW-1:0]             lo_d, lo_q;
  logic [MW-1:0]             recip_prod;
  logic [QW-1:0]             quo_d, quo_q;
  logic [SUMW-1:0]           round_sum;
  logic signed [ZW-1:0]      theta_d, theta_q;

  always_comb begin
    mod_v  = (mag_i >= gcd_pkg::DEG_FULL) ? mag_i - gcd_pkg::DEG_FULL : mag_i;
    fold_v = (mod_v > gcd_pkg::DEG_HALF) ? gcd_pkg::DEG_FULL - mod_v : mod_v;
    neg_d  = 1'b0;
    if (COS_FOLD && (fold_v > gcd_pkg::DEG_QUARTER)) begin
      neg_d  = 1'b1;
      fold_v = gcd_pkg::DEG_HALF - fold_v;
    end
    deg_d = fold_v[gcd_pkg::DEG_W-1:0];
  end

  // deg * pi4 / 45 = deg * q + floor(deg * r / 45), the second term by a
  // reciprocal that is exact over its whole input range.
  assign hi_d       = PW'(deg_q) * PW'(gcd_pkg::PI4_DIV45);
  assign lo_d       = XW'(deg_q) * XW'(gcd_pkg::PI4_REM45);
  assign recip_prod = MW'(lo_q) * MW'(gcd_pkg::RECIP45);
  assign quo_d      = QW'(recip_prod >> gcd_pkg::RECIP45_SHIFT);
  assign p_d        = hi_s4_q + PW'(quo_q);
  assign round_sum  = SUMW'(p_q) + (SUMW'(1) << (SH - 1));
  assign theta_d    = ZW'(round_sum >> SH);

  always_ff @(posedge clk_i) begin
    deg_q    <= deg_d;
    neg_s2_q <= neg_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    neg_s3_q <= neg_s2_q;
    hi_s4_q  <= hi_q;
    quo_q    <= quo_d;
    neg_s4_q <= neg_s3_q;
    p_q      <= p_d;
    neg_s5_q <= neg_s4_q;
    theta_q  <= theta_d;
    neg_q    <= neg_s5_q;
  end

  assign theta_o = theta_q;
  assign neg_o   = neg_q;

endmodule

>>> hdl/gcd_cordic_cell.sv
// ----------------------------------------------------------------------------
// gcd_cordic_cell: one registered CORDIC micro-rotation
// Rotation mode steers on the sign of z, vectoring mode on the sign of y.
// ----------------------------------------------------------------------------
module gcd_cordic_cell #(
  parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int STAGE           = 0,
  parameter bit VECTORING       = 1'b0
) (
  input  logic                               clk_i,
  input  logic signed [gcd_pkg::TRIG_W-1:0]  x_i,
  input  logic signed [gcd_pkg::TRIG_W-1:0]  y_i,
  input  logic signed [ANGLE_FRAC_BITS+3:0]  z_i,
  output logic signed [gcd_pkg::TRIG_W-1:0]  x_o,
  output logic signed [gcd_pkg::TRIG_W-1:0]  y_o,
  output logic signed [ANGLE_FRAC_BITS+3:0]  z_o
);

  localparam int XW = gcd_pkg::TRIG_W;
  localparam int ZW = ANGLE_FRAC_BITS + 4;
  localparam logic signed [ZW-1:0] ANGLE = ZW'(gcd_pkg::atan_angle(STAGE, ANGLE_FRAC_BITS));

  logic signed [XW-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  logic                 up;

  // Arithmetic shifts round toward minus infinity.
  assign dx = y_i >>> STAGE;
  assign dy = x_i >>> STAGE;
  assign up = VECTORING ? !y_i[XW-1] : z_i[ZW-1];

  always_comb begin
    if (up) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ANGLE;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ANGLE;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

>>> hdl/gcd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gcd_sqrt_cell: one bit of a restoring integer square root
// Decides root bit BIT from the running remainder and passes both on.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                        clk_i,
  input  logic [gcd_pkg::REM_W-1:0]   rem_i,
  input  logic [gcd_pkg::ROOT_W-1:0]  root_i,
  output logic [gcd_pkg::REM_W-1:0]   rem_o,
  output logic [gcd_pkg::ROOT_W-1:0]  root_o
);

  localparam int RW = gcd_pkg::REM_W;
  localparam int QW = gcd_pkg::ROOT_W;
  localparam int TW = RW + 2;

  logic [TW-1:0] trial;
  logic          fits;
  logic [RW-1:0] rem_d, rem_q;
  logic [QW-1:0] root_d, root_q;

  // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
  assign trial  = (TW'(root_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));
  assign fits   = TW'(rem_i) >= trial;
  assign rem_d  = fits ? rem_i - RW'(trial) : rem_i;
  assign root_d = fits ? (root_i | (QW'(1) << BIT)) : root_i;

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

>>> hdl/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance: pipelined haversine distance between two positions
// Latitude/longitude pairs in degrees Q.16 in, distance in km Q.8 out.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------
//   input    | in        | start high, busy low | start_lat/lon, end_lat/lon
//   result   | out       | done_o strobe        | distance_km_o
//   config   | in        | cfg_we_i             | cfg_wdata_i (radius, km)
//
// A beat is accepted in every cycle; busy never rises. Each result appears on
// distance_km_o with done_o for exactly one cycle. The delay from a beat to
// its result grows with CORDIC_STAGES through the two CORDIC chains and also
// spans the 31-cell square root chain.
// Reset clears only the strobe pipeline and loads the radius with 6371 km.
// The receiver has no way to stall, so nothing in the pipeline ever holds.
//
// Structure: the four angles (both latitudes for cosines, the latitude and
// longitude differences for half-angle sines) run through lanes that differ
// only in fold and shift, each a row of rotation cells. Their products form
// the haversine term a, two square root rows give sqrt(a) and sqrt(1 - a),
// and vectoring cells give half the central angle, scaled by twice the radius.
// ----------------------------------------------------------------------------
module great_circle_distance #(
  parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = gcd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [gcd_pkg::RADIUS_W-1:0]  cfg_wdata_i,
  input  logic signed [23:0]            start_lat_i,
  input  logic signed [24:0]            start_lon_i,
  input  logic signed [23:0]            end_lat_i,
  input  logic signed [24:0]            end_lon_i,
  output logic                          done_o,
  output logic [gcd_pkg::DIST_W-1:0]    distance_km_o
);

  localparam int ZW      = ANGLE_FRAC_BITS + 4;
  localparam int XW      = gcd_pkg::TRIG_W;
  localparam int UW      = gcd_pkg::UNIT_W;
  localparam int NS      = CORDIC_STAGES;
  localparam int LAT     = gcd_pkg::latency(CORDIC_STAGES);
  localparam int NEG_DLY = CORDIC_STAGES + 4;
  localparam int SQ      = gcd_pkg::SQRT_STEPS;
  localparam int PRW     = gcd_pkg::RADIUS_W + ZW - 1;
  localparam int SUMW    = PRW + gcd_pkg::DIST_SHIFT + 1;

  // Lanes: 0 and 1 are the latitudes (cosine), 2 and 3 the differences
  // of latitude and longitude (sine of the half angle).
  localparam int LANES = 4;

  function automatic logic [UW-1:0] clamp_unit(input logic signed [XW-1:0] v);
    if (v[XW-1]) begin
      return '0;
    end else if (v > $signed(XW'(gcd_pkg::ONE_Q30))) begin
      return gcd_pkg::ONE_Q30;
    end
    return v[UW-1:0];
  endfunction

  // Q.30 product, truncated back to Q.30; both factors lie in [0, 1].
  function automatic logic [UW-1:0] mul_q30(input logic [UW-1:0] a,
                                            input logic [UW-1:0] b);
    logic [2*UW-1:0] p;
    p = (2*UW)'(a) * (2*UW)'(b);
    return p[UW+gcd_pkg::Q30_FRAC-1:gcd_pkg::Q30_FRAC];
  endfunction

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Radius register: the user loads it only while no beat is in flight; not enforced.
  logic [gcd_pkg::RADIUS_W-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= gcd_pkg::RADIUS_W'(6371);
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // Strobe pipeline: one valid bit per register stage.
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // Stage 1: magnitudes of the latitudes and of the coordinate differences.
  logic signed [25:0]        dlat;
  logic signed [26:0]        dlon;
  logic [gcd_pkg::MAG_W-1:0] mag_d [LANES];
  logic [gcd_pkg::MAG_W-1:0] mag_q [LANES];

  always_comb begin
    dlat = 26'(end_lat_i) - 26'(start_lat_i);
    dlon = 27'(end_lon_i) - 27'(start_lon_i);
    mag_d[0] = start_lat_i[23] ? gcd_pkg::MAG_W'(-25'(start_lat_i))
                               : gcd_pkg::MAG_W'(start_lat_i);
    mag_d[1] = end_lat_i[23] ? gcd_pkg::MAG_W'(-25'(end_lat_i))
                             : gcd_pkg::MAG_W'(end_lat_i);
    mag_d[2] = dlat[25] ? gcd_pkg::MAG_W'(-dlat) : gcd_pkg::MAG_W'(dlat);
    mag_d[3] = dlon[26] ? gcd_pkg::MAG_W'(-dlon) : gcd_pkg::MAG_W'(dlon);
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  // Stages 2 to 6 in the lanes, then one row of rotation cells per lane.
  logic signed [ZW-1:0] theta [LANES];
  logic                 neg   [LANES];
  logic signed [XW-1:0] rot_x [LANES][NS+1];
  logic signed [XW-1:0] rot_y [LANES][NS+1];
  logic signed [ZW-1:0] rot_z [LANES][NS+1];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    gcd_angle_lane #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .COS_FOLD        (l < 2),
      .EXTRA_SHIFT     ((l < 2) ? 0 : 1)
    ) u_angle (
      .clk_i   (clk_i),
      .mag_i   (mag_q[l]),
      .theta_o (theta[l]),
      .neg_o   (neg[l])
    );

    assign rot_x[l][0] = gcd_pkg::CORDIC_GAIN;
    assign rot_y[l][0] = '0;
    assign rot_z[l][0] = theta[l];

    for (genvar i = 0; i < NS; i++) begin : g_rot
      gcd_cordic_cell #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .STAGE           (i),
        .VECTORING       (1'b0)
      ) u_cell (
        .clk_i (clk_i),
        .x_i   (rot_x[l][i]),
        .y_i   (rot_y[l][i]),
        .z_i   (rot_z[l][i]),
        .x_o   (rot_x[l][i+1]),
        .y_o   (rot_y[l][i+1]),
        .z_o   (rot_z[l][i+1])
      );
    end
  end

  // Cosine signs of the two latitudes travel alongside the trig rows.
  logic [1:0] neg_pipe_q [NEG_DLY];

  always_ff @(posedge clk_i) begin
    neg_pipe_q[0] <= {neg[1], neg[0]};
    for (int k = 1; k < NEG_DLY; k++) begin
      neg_pipe_q[k] <= neg_pipe_q[k-1];
    end
  end

  // Clamp sines and cosines to [0, 1], then form the haversine term:
  // a = sin^2(dlat/2) +- sin^2(dlon/2) * cos(lat1) * cos(lat2).
  logic [UW-1:0] unit_q [LANES];
  logic [UW-1:0] sq_lat_q, sq_lon_q, cos1_m1_q, cos2_m1_q;
  logic [UW-1:0] t1_q, sq_lat_m2_q, cos2_m2_q;
  logic [UW-1:0] term_q, sq_lat_m3_q;
  logic signed [UW+1:0] a_sum;
  logic [UW-1:0] a_d, a_q, b_q;

  always_comb begin
    if (neg_pipe_q[NEG_DLY-1][0] != neg_pipe_q[NEG_DLY-1][1]) begin
      a_sum = $signed({2'b00, sq_lat_m3_q}) - $signed({2'b00, term_q});
    end else begin
      a_sum = $signed({2'b00, sq_lat_m3_q}) + $signed({2'b00, term_q});
    end
    if (a_sum[UW+1]) begin
      a_d = '0;
    end else if (a_sum > $signed((UW+2)'(gcd_pkg::ONE_Q30))) begin
      a_d = gcd_pkg::ONE_Q30;
    end else begin
      a_d = a_sum[UW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q[0]   <= clamp_unit(rot_x[0][NS]);
    unit_q[1]   <= clamp_unit(rot_x[1][NS]);
    unit_q[2]   <= clamp_unit(rot_y[2][NS]);
    unit_q[3]   <= clamp_unit(rot_y[3][NS]);
    sq_lat_q    <= mul_q30(unit_q[2], unit_q[2]);
    sq_lon_q    <= mul_q30(unit_q[3], unit_q[3]);
    cos1_m1_q   <= unit_q[0];
    cos2_m1_q   <= unit_q[1];
    t1_q        <= mul_q30(sq_lon_q, cos1_m1_q);
    sq_lat_m2_q <= sq_lat_q;
    cos2_m2_q   <= cos2_m1_q;
    term_q      <= mul_q30(t1_q, cos2_m2_q);
    sq_lat_m3_q <= sq_lat_m2_q;
    a_q         <= a_d;
    b_q         <= gcd_pkg::ONE_Q30 - a_d;
  end

  // Square roots of a and 1 - a, both scaled by 2^30, one bit per cell.
  // Row 0 works on a (gives y), row 1 on 1 - a (gives x).
  logic [gcd_pkg::REM_W-1:0]  sq_rem  [2][SQ+1];
  logic [gcd_pkg::ROOT_W-1:0] sq_root [2][SQ+1];

  assign sq_rem[0][0]  = {a_q, {gcd_pkg::Q30_FRAC{1'b0}}};
  assign sq_rem[1][0]  = {b_q, {gcd_pkg::Q30_FRAC{1'b0}}};
  assign sq_root[0][0] = '0;
  assign sq_root[1][0] = '0;

  for (genvar r = 0; r < 2; r++) begin : g_sqrt_row
    for (genvar j = 0; j < SQ; j++) begin : g_sqrt
      gcd_sqrt_cell #(
        .BIT (SQ - 1 - j)
      ) u_cell (
        .clk_i  (clk_i),
        .rem_i  (sq_rem[r][j]),
        .root_i (sq_root[r][j]),
        .rem_o  (sq_rem[r][j+1]),
        .root_o (sq_root[r][j+1])
      );
    end
  end

  // Vectoring row: atan2(sqrt(a), sqrt(1 - a)) is half the central angle.
  logic signed [XW-1:0] vec_x [NS+1];
  logic signed [XW-1:0] vec_y [NS+1];
  logic signed [ZW-1:0] vec_z [NS+1];

  assign vec_x[0] = $signed(XW'(sq_root[1][SQ]));
  assign vec_y[0] = $signed(XW'(sq_root[0][SQ]));
  assign vec_z[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_vec
    gcd_cordic_cell #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .STAGE           (i),
      .VECTORING       (1'b1)
    ) u_cell (
      .clk_i (clk_i),
      .x_i   (vec_x[i]),
      .y_i   (vec_y[i]),
      .z_i   (vec_z[i]),
      .x_o   (vec_x[i+1]),
      .y_o   (vec_y[i+1]),
      .z_o   (vec_z[i+1])
    );
  end

  // Scale by the radius; the factor 2 of the central angle and the Q.8
  // output format fold into one left shift, then round and saturate.
  logic [ZW-2:0]                 angle_pos;
  logic [PRW-1:0]                prod_d, prod_q;
  logic [SUMW-1:0]               round_sum, scaled;
  logic [gcd_pkg::DIST_W-1:0]    dist_d, dist_q;

  assign angle_pos = vec_z[NS][ZW-1] ? '0 : vec_z[NS][ZW-2:0];
  assign prod_d    = PRW'(radius_q) * PRW'(angle_pos);
  assign round_sum = (SUMW'(prod_q) << gcd_pkg::DIST_SHIFT)
                   + (SUMW'(1) << (ANGLE_FRAC_BITS - 1));
  assign scaled    = round_sum >> ANGLE_FRAC_BITS;
  assign dist_d    = (scaled > SUMW'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX
                                                         : scaled[gcd_pkg::DIST_W-1:0];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    dist_q <= dist_d;
  end

  assign done_o        = vld_q[LAT-1];
  assign distance_km_o = dist_q;

endmodule

>>> hdl/gcd_checker.sv
// ----------------------------------------------------------------------------
// gcd_checker: port-level checks for the great-circle distance block
// Every accepted beat gives exactly one strobe after the fixed latency.
// ----------------------------------------------------------------------------
module gcd_checker #(
  parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  localparam int LAT = gcd_pkg::latency(CORDIC_STAGES);

  // An accepted beat produces its result strobe after the pipeline latency.
  a_beat_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("accepted beat produced no result strobe");

  // No strobe appears without a beat accepted the same latency earlier.
  a_result_from_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && rst_ni, LAT))
    else $error("result strobe without a matching beat");

  // The pipeline takes a beat in every cycle.
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised although the pipeline never stalls");

endmodule

bind great_circle_distance gcd_checker #(
  .CORDIC_STAGES (CORDIC_STAGES)
) u_gcd_checker (.*);

>>> sim/great_circle_distance_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// great_circle_distance_tb: self-checking bench for the haversine pipeline
// Position pairs are driven as beats under several sphere radii. Each beat is
// scored against its typed result or a bit-true fixed-point model kept here.
// ----------------------------------------------------------------------------
module great_circle_distance_tb;

  localparam int STAGES  = gcd_pkg::CORDIC_STAGES_DEF;
  localparam int FRAC    = gcd_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int LATENCY = gcd_pkg::latency(STAGES);
  localparam longint LAT_MAX = 5898240;
  localparam longint LON_MAX = 11796480;

  // Directed rows: the radius in force, the two positions, and optionally a
  // result that is obvious without any arithmetic.
  typedef struct {
    logic [gcd_pkg::RADIUS_W-1:0] radius;
    logic signed [23:0]           lat1;
    logic signed [24:0]           lon1;
    logic signed [23:0]           lat2;
    logic signed [24:0]           lon2;
    bit                           typed;
    logic [gcd_pkg::DIST_W-1:0]   want_km;
  } route_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         cfg_we_i = 1'b0;
  logic [gcd_pkg::RADIUS_W-1:0] cfg_wdata_i = '0;
  logic signed [23:0]           start_lat_i = '0;
  logic signed [24:0]           start_lon_i = '0;
  logic signed [23:0]           end_lat_i = '0;
  logic signed [24:0]           end_lon_i = '0;
  logic                         done_o;
  logic [gcd_pkg::DIST_W-1:0]   distance_km_o;

  // The typed expectation travels with the beat that it belongs to.
  bit                           typed_beat = 1'b0;
  logic [gcd_pkg::DIST_W-1:0]   typed_dist = '0;

  logic [gcd_pkg::RADIUS_W-1:0] radius_km = 13'd6371;
  logic [gcd_pkg::DIST_W-1:0]   pending_dist[$];
  int                           mismatches = 0;
  int                           beats_sent = 0;
  int                           results_seen = 0;
  int                           send_idle_pct = 0;

  always #4 clk_i = ~clk_i;

  great_circle_distance dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_lat_i  (start_lat_i),
    .start_lon_i  (start_lon_i),
    .end_lat_i    (end_lat_i),
    .end_lon_i    (end_lon_i),
    .done_o       (done_o),
    .distance_km_o(distance_km_o)
  );

  // --------------------------------------------------------------------------
  // Distance model. All arithmetic is done in 64 bits; the arithmetic right
  // shift of a signed longint already rounds toward minus infinity, which is
  // exactly what the CORDIC cells do.
  // --------------------------------------------------------------------------

  // Elementary rotation angle of stage idx in radians with FRAC fraction bits.
  function automatic longint step_angle(input int idx);
    return longint'(gcd_pkg::ATAN_Q30[idx[4:0]] >> (30 - FRAC));
  endfunction

  // Folded degrees Q.16 in [0, 180] to radians, one more shift for a half angle.
  function automatic longint deg_to_radians(input longint unsigned deg, input int extra);
    int                    sh;
    longint unsigned       prod;
    sh   = 48 - FRAC + extra;
    prod = deg * 64'hC90FDAA2 / 45;
    return longint'((prod + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic longint clamp_q30(input longint v);
    if (v < 0) return 0;
    if (v > (64'sd1 <<< 30)) return 64'sd1 <<< 30;
    return v;
  endfunction

  // Rotation CORDIC: sine and cosine of theta, clamped to [0, 1] in Q.30.
  function automatic void rotate_unit(input longint theta, output longint sn,
                                      output longint cs);
    longint x, y, z, dx, dy;
    x = longint'(gcd_pkg::CORDIC_GAIN);
    y = 0;
    z = theta;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= step_angle(i);
      end else begin
        x += dx; y -= dy; z += step_angle(i);
      end
    end
    sn = clamp_q30(y);
    cs = clamp_q30(x);
  endfunction

  // Vectoring CORDIC: atan2(y, x) for x >= 0.
  function automatic longint vector_angle(input longint y, input longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += step_angle(i);
      end else begin
        x -= dx; y += dy; z -= step_angle(i);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Magnitude reduced modulo a full turn, then folded into [0, 180] degrees.
  function automatic longint unsigned fold_degrees(input longint d);
    longint unsigned m;
    m = longint'(d < 0 ? -d : d) % longint'(gcd_pkg::DEG_FULL);
    return (m > gcd_pkg::DEG_HALF) ? gcd_pkg::DEG_FULL - m : m;
  endfunction

  function automatic longint half_sine_sq(input longint d);
    longint sn, cs;
    rotate_unit(deg_to_radians(fold_degrees(d), 1), sn, cs);
    return (sn * sn) >>> 30;
  endfunction

  // Cosine magnitude of a latitude; a fold past 90 degrees flips the sign.
  function automatic longint lat_cosine(input longint lat, output bit neg);
    longint unsigned m;
    longint sn, cs;
    m   = fold_degrees(lat);
    neg = 1'b0;
    if (m > gcd_pkg::DEG_QUARTER) begin
      neg = 1'b1;
      m   = gcd_pkg::DEG_HALF - m;
    end
    rotate_unit(deg_to_radians(m, 0), sn, cs);
    return cs;
  endfunction

  function automatic logic [gcd_pkg::DIST_W-1:0] route_distance(
      input logic signed [23:0] lat1, input logic signed [24:0] lon1,
      input logic signed [23:0] lat2, input logic signed [24:0] lon2,
      input logic [gcd_pkg::RADIUS_W-1:0] radius);
    bit              n1, n2;
    longint          c1, c2, slat, slon, term, hav, ys, xs, z;
    longint unsigned arc, num, km_q8;
    c1   = lat_cosine(longint'(lat1), n1);
    c2   = lat_cosine(longint'(lat2), n2);
    slat = half_sine_sq(longint'(lat2) - longint'(lat1));
    slon = half_sine_sq(longint'(lon2) - longint'(lon1));
    term = (((slon * c1) >>> 30) * c2) >>> 30;
    // Latitudes on opposite sides of a fold make the cosine product negative.
    hav  = clamp_q30(slat + ((n1 != n2) ? -term : term));
    ys   = longint'(floor_sqrt(longint'(hav) << 30));
    xs   = longint'(floor_sqrt(longint'((64'sd1 <<< 30) - hav) << 30));
    z    = vector_angle(ys, xs);
    arc  = (z < 0) ? 0 : z;
    num  = (longint'(radius) * arc) << 9;
    km_q8 = (num + (64'd1 << (FRAC - 1))) >> FRAC;
    if (km_q8 > gcd_pkg::DIST_MAX) km_q8 = gcd_pkg::DIST_MAX;
    return km_q8[gcd_pkg::DIST_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard. Inputs move on the falling edge, so everything sampled here
  // at the rising edge is settled. An accepted beat queues its expected
  // distance; a strobe retires the oldest one.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) radius_km <= cfg_wdata_i;
      if (start && !busy) begin
        beats_sent++;
        if (typed_beat)
          pending_dist.push_back(typed_dist);
        else
          pending_dist.push_back(route_distance(start_lat_i, start_lon_i,
                                                end_lat_i, end_lon_i, radius_km));
      end
      if (done_o) begin
        results_seen++;
        if (pending_dist.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d with no beat outstanding", distance_km_o);
        end else begin
          logic [gcd_pkg::DIST_W-1:0] want;
          want = pending_dist.pop_front();
          if (distance_km_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: distance_km expected %0d got %0d", want, distance_km_o);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. Every task starts and ends on a falling edge.
  // --------------------------------------------------------------------------

  // Lets the pipeline run dry before the radius is touched again.
  task automatic drain_pipeline();
    while (pending_dist.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic set_radius(input logic [gcd_pkg::RADIUS_W-1:0] r);
    drain_pipeline();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = r;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Drives one beat, idling the sender for a random number of cycles first,
  // and waits for acceptance.
  task automatic send_route(input logic signed [23:0] lat1, input logic signed [24:0] lon1,
                            input logic signed [23:0] lat2, input logic signed [24:0] lon2,
                            input bit typed, input logic [gcd_pkg::DIST_W-1:0] typed_km);
    while ($urandom_range(99) < send_idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start_lat_i = lat1;
    start_lon_i = lon1;
    end_lat_i   = lat2;
    end_lon_i   = lon2;
    typed_beat  = typed;
    typed_dist  = typed_km;
    start       = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic signed [23:0] pick_lat(input bit wild);
    if (wild) return 24'($urandom());
    return 24'(longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
  endfunction

  function automatic logic signed [24:0] pick_lon(input bit wild);
    if (wild) return 25'($urandom());
    return 25'(longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
  endfunction

  // Mostly legal coordinates; some raw bit patterns that lie past the poles or
  // the date line, and some pairs that sit close together or exactly opposite.
  task automatic send_random_routes(input int count);
    logic signed [23:0] lat1, lat2;
    logic signed [24:0] lon1, lon2;
    int                 kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      lat1 = pick_lat(kind < 15);
      lon1 = pick_lon(kind < 15);
      lat2 = pick_lat(kind < 15);
      lon2 = pick_lon(kind < 15);
      if (kind >= 15 && kind < 30) begin
        lat2 = lat1 + $signed(24'($urandom_range(0, 511)) - 24'd256);
        lon2 = lon1 + $signed(25'($urandom_range(0, 511)) - 25'd256);
      end else if (kind >= 30 && kind < 40) begin
        lat2 = -lat1;
        lon2 = (lon1 >= 0) ? lon1 - 25'(LON_MAX) : lon1 + 25'(LON_MAX);
      end
      send_route(lat1, lon1, lat2, lon2, 1'b0, '0);
    end
  endtask

  route_row_t routes[] = '{
    // Default radius: origin, poles, equator, date line, corners of the range.
    '{13'd6371, 24'sd0, 25'sd0, 24'sd0, 25'sd0, 1'b0, '0},
    '{13'd6371, 24'sd5898240, 25'sd0, -24'sd5898240, 25'sd0, 1'b0, '0},
    '{13'd6371, 24'sd0, 25'sd0, 24'sd0, 25'sd11796480, 1'b0, '0},
    '{13'd6371, 24'sd0, -25'sd11796480, 24'sd0, 25'sd11796480, 1'b0, '0},
    '{13'd6371, 24'sd5898240, 25'sd11796480, 24'sd5898240, -25'sd11796480, 1'b0, '0},
    '{13'd6371, -24'sd5898240, -25'sd11796480, 24'sd5898240, 25'sd11796480, 1'b0, '0},
    '{13'd6371, 24'sd3342336, 25'sd851968, 24'sd2555904, -25'sd4915200, 1'b0, '0},
    '{13'd6371, 24'sd1, 25'sd1, 24'sd0, 25'sd0, 1'b0, '0},
    // Field extremes beyond the legal range: reduced modulo a full turn.
    '{13'd6371, 24'h7FFFFF, 25'h0FFFFFF, 24'h800000, 25'h1000000, 1'b0, '0},
    '{13'd6371, 24'h800000, 25'h1000000, 24'h800000, 25'h1000000, 1'b0, '0},
    '{13'd6371, 24'sd7864320, 25'sd0, 24'sd0, 25'sd0, 1'b0, '0},
    // Latitudes folded to opposite sides give a negative cosine product.
    '{13'd6371, 24'sd7864320, 25'sd5898240, 24'sd1966080, -25'sd5898240, 1'b0, '0},
    '{13'd6371, -24'sd7864320, 25'sd11796480, 24'sd5898240, 25'sd0, 1'b0, '0},
    // Zero radius: every distance is zero.
    '{13'd0, 24'sd5898240, 25'sd0, -24'sd5898240, 25'sd0, 1'b1, 23'd0},
    '{13'd0, 24'sd0, 25'sd0, 24'sd0, 25'sd11796480, 1'b1, 23'd0},
    // Largest radius: two half great circles, the longest distances, and a short one.
    '{13'd8191, 24'sd5898240, 25'sd0, -24'sd5898240, 25'sd0, 1'b0, '0},
    '{13'd8191, 24'sd0, 25'sd0, 24'sd0, 25'sd11796480, 1'b0, '0},
    '{13'd8191, 24'sd655360, 25'sd65536, 24'sd655360, 25'sd131072, 1'b0, '0},
    // Smallest nonzero radius.
    '{13'd1, 24'sd5898240, 25'sd0, -24'sd5898240, 25'sd0, 1'b0, '0},
    '{13'd1, 24'sd123456, -25'sd654321, -24'sd2345678, 25'sd9876543, 1'b0, '0}
  };

  initial begin
    logic [gcd_pkg::RADIUS_W-1:0] radius_now;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table; the radius register follows the rows. No sender gaps.
    radius_now = 13'd6371;
    foreach (routes[k]) begin
      if (routes[k].radius != radius_now) begin
        start = 1'b0;
        set_radius(routes[k].radius);
        radius_now = routes[k].radius;
      end
      send_route(routes[k].lat1, routes[k].lon1, routes[k].lat2, routes[k].lon2,
                 routes[k].typed, routes[k].want_km);
    end
    start = 1'b0;

    // Random beats: light sender gaps, then heavy ones, then back to back.
    set_radius(13'd8191);
    send_idle_pct = 24;
    send_random_routes(500);
    start = 1'b0;

    set_radius(13'd1);
    send_idle_pct = 88;
    send_random_routes(450);
    start = 1'b0;

    set_radius(13'd0);
    send_idle_pct = 0;
    send_random_routes(50);
    start = 1'b0;

    set_radius(13'd6371);
    send_random_routes(250);
    start = 1'b0;

    set_radius(13'($urandom_range(2, 8190)));
    send_random_routes(250);
    start = 1'b0;

    drain_pipeline();
    if (pending_dist.size() != 0) mismatches++;
    $display("Covered %0d beats and %0d distances over several radius settings,",
             beats_sent, results_seen);
    $display("with the sender idling in none, light and heavy patterns.");
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
